// File: rtl/core/wgm_pkg.sv
`timescale 1ns / 1ps

package wgm_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int LEN_W       = 5;
    localparam int CFG_IDX_W   = 2;

    localparam logic [7:0] CH_ANY = 8'h3F;
    localparam logic [7:0] CH_RUN = 8'h2A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2
    } wgm_cfg_idx_t;

    // carried from cell i to cell i+1
    typedef struct packed {
        logic carry;
        logic fcarry;
        logic adv;
    } wgm_fwd_t;

    // carried from cell i+1 back to cell i
    typedef struct packed {
        logic star;
        logic any;
    } wgm_flags_t;

endpackage

// File: rtl/core/wgm_cell.sv
`timescale 1ns / 1ps

module wgm_cell
    import wgm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start_i,
    input  logic [7:0] pat_byte_i,
    input  logic       en_i,
    input  logic       next_en_i,
    input  logic       at_end_i,
    input  logic [7:0] text_byte_i,
    input  logic       step_i,
    input  logic       advance_i,
    input  logic       finish_i,
    input  wgm_fwd_t   fwd_i,
    output wgm_fwd_t   fwd_o,
    input  wgm_flags_t nbr_flags_i,
    output wgm_flags_t flags_o,
    output logic       hit_o,
    output logic       bad_o
);

    logic live_reg, live_next;
    logic fin_reg, fin_next;
    logic is_star, is_any;
    logic clos, act, stay, nval, fclos;

    always_comb begin
        is_star = (pat_byte_i == CH_RUN);
        is_any  = (pat_byte_i == CH_ANY);
        clos    = live_reg | fwd_i.carry;
        act     = clos & en_i;
        stay    = act & is_star;

        fwd_o.carry  = stay;
        fwd_o.adv    = act & ~is_star & (is_any | (pat_byte_i == text_byte_i));
        fclos        = fin_reg | fwd_i.fcarry;
        fwd_o.fcarry = fclos & en_i & is_star;

        flags_o.star = is_star;
        flags_o.any  = is_any;
        hit_o        = fclos & at_end_i;
        bad_o        = next_en_i & is_star & (nbr_flags_i.star | nbr_flags_i.any);

        nval      = step_i ? (stay | fwd_i.adv) : live_reg;
        live_next = live_reg;
        fin_next  = fin_reg;
        if (advance_i) begin
            if (finish_i) begin
                fin_next  = nval;
                live_next = start_i;
            end else begin
                live_next = nval;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= start_i;
        end else begin
            live_reg <= live_next;
        end
    end

    always_ff @(posedge aclk) begin
        fin_reg <= fin_next;
    end

endmodule

// File: rtl/core/wildcard_glob_matcher_top.sv
// A request carrying tlast sets pend_reg; the result is registered into m_tdata when the output
// is free. Throughput: one request per cycle while no result stalls; the live-position update
// runs combinationally across sixteen cells, including the ripple through '*' positions.
// Reset: pattern registers clear to zero, the live set holds only the start position,
// and no result is pending.
`timescale 1ns / 1ps

module wildcard_glob_matcher_top
    import wgm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] text_byte
    input  logic                 s_tuser,   // [0] byte_present
    input  logic                 s_tlast,   // last_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [0] matched, [7:1] zero
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    logic [63:0]      pat_low_reg, pat_low_next;
    logic [63:0]      pat_high_reg, pat_high_next;
    logic [LEN_W-1:0] pat_len_reg, pat_len_next;
    logic [LEN_W-1:0] used_len;
    logic [127:0]     pattern;

    logic pend_reg, pend_next;
    logic m_valid_reg, m_valid_next;
    logic matched_reg, matched_next;
    logic live_end_reg, live_end_next;
    logic fin_end_reg, fin_end_next;

    logic accept, step, pend_move, fclos_end, ok;

    wgm_fwd_t   fwd   [PATTERN_MAX:0];
    wgm_flags_t flags [PATTERN_MAX:0];
    logic [PATTERN_MAX:0]   hits;
    logic [PATTERN_MAX-1:0] bads;

    assign cfg_ready = 1'b1;
    assign pattern   = {pat_high_reg, pat_low_reg};
    assign used_len  = (pat_len_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_reg;

    always_comb begin
        pat_low_next  = pat_low_reg;
        pat_high_next = pat_high_reg;
        pat_len_next  = pat_len_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PAT_LOW:  pat_low_next  = cfg_data;
                CFG_PAT_HIGH: pat_high_next = cfg_data;
                CFG_PAT_LEN:  pat_len_next  = cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end else begin
            pat_low_reg  <= pat_low_next;
            pat_high_reg <= pat_high_next;
            pat_len_reg  <= pat_len_next;
        end
    end

    assign pend_move = pend_reg & (~m_valid_reg | m_tready);
    assign s_tready  = ~pend_reg | pend_move;
    assign accept    = s_tvalid & s_tready;
    assign step      = accept & s_tuser;

    assign fwd[0]             = '0;
    assign flags[PATTERN_MAX] = '0;

    genvar i;
    generate
        for (i = 0; i < PATTERN_MAX; i++) begin : g_cell
            wgm_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .start_i     (1'(i == 0)),
                .pat_byte_i  (pattern[8*i +: 8]),
                .en_i        (LEN_W'(i) < used_len),
                .next_en_i   (LEN_W'(i + 1) < used_len),
                .at_end_i    (LEN_W'(i) == used_len),
                .text_byte_i (s_tdata),
                .step_i      (step),
                .advance_i   (accept),
                .finish_i    (s_tlast),
                .fwd_i       (fwd[i]),
                .fwd_o       (fwd[i+1]),
                .nbr_flags_i (flags[i+1]),
                .flags_o     (flags[i]),
                .hit_o       (hits[i]),
                .bad_o       (bads[i])
            );
        end
    endgenerate

    // final position, beyond the last cell
    always_comb begin
        logic nval;
        nval          = step ? fwd[PATTERN_MAX].adv : live_end_reg;
        live_end_next = live_end_reg;
        fin_end_next  = fin_end_reg;
        if (accept) begin
            if (s_tlast) begin
                fin_end_next  = nval;
                live_end_next = 1'b0;
            end else begin
                live_end_next = nval;
            end
        end
    end

    assign fclos_end         = fin_end_reg | fwd[PATTERN_MAX].fcarry;
    assign hits[PATTERN_MAX] = fclos_end & (used_len == LEN_W'(PATTERN_MAX));
    assign ok                = (|hits) & ~(|bads);

    always_comb begin
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        matched_next = matched_reg;
        if (pend_move) begin
            pend_next    = 1'b0;
            m_valid_next = 1'b1;
            matched_next = ok;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept && s_tlast) begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            live_end_reg <= 1'b0;
        end else begin
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
            live_end_reg <= live_end_next;
        end
    end

    always_ff @(posedge aclk) begin
        matched_reg <= matched_next;
        fin_end_reg <= fin_end_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, matched_reg};

endmodule
